>>> design/lprt_pkg.sv
// ----------------------------------------------------------------------------
// lprt_pkg: shared constants for the lidar ring and time block
// Angle table, datapath widths, register codes and reset values.
// ----------------------------------------------------------------------------
package lprt_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int ANGLE_FRAC_DEF  = 14;

    localparam int CORDIC_STEPS = 31;
    localparam int NORM_STAGES  = 6;
    // Normalized operands sit in [2^40, 2^41); gain and diagonal growth stay below 2^43.
    localparam int NW = 44;
    // Binary angle, 2^32 per turn, with headroom for the half-turn pre-rotation.
    localparam int BW = 34;
    // prep, normalize, CORDIC steps, magnitude, scale multiply, rounding
    localparam int ATAN_LAT = NORM_STAGES + CORDIC_STEPS + 4;

    localparam logic [31:0] PI30 = 32'd3373259426;
    localparam logic signed [BW-1:0] HALF_TURN = 34'sh0_8000_0000;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
        30'h00000001
    };

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_FOV_MIN = 2'd0;
    localparam reg_idx_t REG_FOV_MAX = 2'd1;
    localparam reg_idx_t REG_LINES   = 2'd2;
    localparam reg_idx_t REG_PERIOD  = 2'd3;

    localparam logic signed [15:0] FOV_MIN_RST = -16'sd4289;
    localparam logic signed [15:0] FOV_MAX_RST = 16'sd4289;
    localparam logic [7:0]         LINES_RST   = 8'd16;
    localparam logic [19:0]        PERIOD_RST  = 20'd100000;

endpackage

>>> design/lprt_sqrt_cell.sv
// ----------------------------------------------------------------------------
// lprt_sqrt_cell: one root bit of a digit-by-digit integer square root
// Brings down the next bit pair of the radicand and trial-subtracts.
// ----------------------------------------------------------------------------
module lprt_sqrt_cell #(
    parameter int W    = 24,
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic [2*W-1:0]   rad_in,
    input  logic [W-1:0]     root_in,
    input  logic [W+2:0]     rem_in,
    output logic [2*W-1:0]   rad_out,
    output logic [W-1:0]     root_out,
    output logic [W+2:0]     rem_out
);
    localparam int HI = 2*W - 1 - 2*STEP;

    logic [2*W-1:0] rad_reg;
    logic [W-1:0]   root_reg, root_next;
    logic [W+2:0]   rem_reg, rem_next;
    logic [W+2:0]   rem_sh;
    logic [W+2:0]   trial;

    always_comb
    begin
        rem_sh = {rem_in[W:0], rad_in[HI -: 2]};
        trial  = {1'b0, root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_in[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_in;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule

>>> design/lprt_cordic_cell.sv
// ----------------------------------------------------------------------------
// lprt_cordic_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis and accumulates the binary angle.
// ----------------------------------------------------------------------------
module lprt_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                            clk,
    input  logic signed [lprt_pkg::NW-1:0]  x_in,
    input  logic signed [lprt_pkg::NW-1:0]  y_in,
    input  logic signed [lprt_pkg::BW-1:0]  ang_in,
    output logic signed [lprt_pkg::NW-1:0]  x_out,
    output logic signed [lprt_pkg::NW-1:0]  y_out,
    output logic signed [lprt_pkg::BW-1:0]  ang_out
);
    import lprt_pkg::*;

    localparam logic signed [BW-1:0] STEP_ANG = {{(BW-30){1'b0}}, ATAN_TAB[STEP]};

    logic signed [NW-1:0] x_reg, x_next;
    logic signed [NW-1:0] y_reg, y_next;
    logic signed [BW-1:0] ang_reg, ang_next;
    logic signed [NW-1:0] dx, dy;

    always_comb
    begin
        dx = x_in >>> STEP;
        dy = y_in >>> STEP;
        if (!y_in[NW-1])
        begin
            x_next   = x_in + dy;
            y_next   = y_in - dx;
            ang_next = ang_in + STEP_ANG;
        end
        else
        begin
            x_next   = x_in - dy;
            y_next   = y_in + dx;
            ang_next = ang_in - STEP_ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

>>> design/lprt_div_cell.sv
// ----------------------------------------------------------------------------
// lprt_div_cell: one quotient bit of a restoring divider
// Compares the partial remainder with the shifted divisor and subtracts.
// ----------------------------------------------------------------------------
module lprt_div_cell #(
    parameter int RW  = 26,
    parameter int QW  = 8,
    parameter int DVW = 17,
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic [RW-1:0]  rem_in,
    input  logic [QW-1:0]  quo_in,
    input  logic [DVW-1:0] divisor,
    output logic [RW-1:0]  rem_out,
    output logic [QW-1:0]  quo_out
);
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [RW-1:0] trial;

    assign trial = RW'(divisor) << BIT;

    always_comb
    begin
        if (rem_in >= trial)
        begin
            rem_next = rem_in - trial;
            quo_next = {quo_in[QW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_in;
            quo_next = {quo_in[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

>>> design/lprt_atan.sv
// ----------------------------------------------------------------------------
// lprt_atan: pipelined atan2(y, x) in radians times 2^F
// Half-turn pre-rotation, normalization, CORDIC chain and rounded scaling.
// ----------------------------------------------------------------------------
module lprt_atan #(
    parameter int IW = 25,
    parameter int AW = 18,
    parameter int F  = 14
) (
    input  logic                 clk,
    input  logic signed [IW-1:0] y_in,
    input  logic signed [IW-1:0] x_in,
    output logic signed [AW-1:0] angle_out
);
    import lprt_pkg::*;

    localparam int SH = 61 - F;
    localparam logic [64:0] ROUND = 65'd1 << (SH - 1);
    localparam int ZL = ATAN_LAT - 1;

    // Prep and normalize stages, index 0 is the prep register.
    logic signed [NW-1:0] nx_reg [NORM_STAGES+1];
    logic signed [NW-1:0] ny_reg [NORM_STAGES+1];
    logic        [NW-1:0] nm_reg [NORM_STAGES+1];
    logic signed [BW-1:0] na_reg [NORM_STAGES+1];
    logic                 z_reg  [ZL];

    logic signed [NW-1:0] x_e, y_e, xp, yp, ay;
    logic                 neg_x;

    always_comb
    begin
        x_e   = {{(NW-IW){x_in[IW-1]}}, x_in};
        y_e   = {{(NW-IW){y_in[IW-1]}}, y_in};
        neg_x = x_in[IW-1];
        xp    = neg_x ? -x_e : x_e;
        yp    = neg_x ? -y_e : y_e;
        ay    = yp[NW-1] ? -yp : yp;
    end

    always_ff @(posedge clk)
    begin
        nx_reg[0] <= xp;
        ny_reg[0] <= yp;
        nm_reg[0] <= (xp > ay) ? xp : ay;
        if (neg_x)
            na_reg[0] <= y_in[IW-1] ? -HALF_TURN : HALF_TURN;
        else
            na_reg[0] <= '0;
        z_reg[0] <= (x_in == '0) && (y_in == '0);
        for (int k = 1; k < ZL; k++)
            z_reg[k] <= z_reg[k-1];
    end

    // Binary-search normalization: the larger magnitude ends in [2^40, 2^41).
    for (genvar j = 0; j < NORM_STAGES; j++)
    begin : g_norm
        localparam int K = 32 >> j;
        localparam logic [NW-1:0] LIM = {{(NW-1){1'b0}}, 1'b1} << (41 - K);
        always_ff @(posedge clk)
        begin
            na_reg[j+1] <= na_reg[j];
            if (nm_reg[j] < LIM)
            begin
                nx_reg[j+1] <= nx_reg[j] <<< K;
                ny_reg[j+1] <= ny_reg[j] <<< K;
                nm_reg[j+1] <= nm_reg[j] << K;
            end
            else
            begin
                nx_reg[j+1] <= nx_reg[j];
                ny_reg[j+1] <= ny_reg[j];
                nm_reg[j+1] <= nm_reg[j];
            end
        end
    end

    logic signed [NW-1:0] cx [CORDIC_STEPS+1];
    logic signed [NW-1:0] cy [CORDIC_STEPS+1];
    logic signed [BW-1:0] ca [CORDIC_STEPS+1];

    assign cx[0] = nx_reg[NORM_STAGES];
    assign cy[0] = ny_reg[NORM_STAGES];
    assign ca[0] = na_reg[NORM_STAGES];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        lprt_cordic_cell #(.STEP(i)) u_cell (
            .clk     (clk),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .ang_in  (ca[i]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .ang_out (ca[i+1])
        );
    end

    logic [31:0]          mag_reg;
    logic                 mneg_reg;
    logic [63:0]          prod_reg;
    logic                 pneg_reg;
    logic signed [AW-1:0] angle_reg, angle_next;
    logic signed [BW-1:0] a_abs;
    logic [64:0]          rnd;
    logic signed [AW-1:0] rmag;

    assign a_abs = ca[CORDIC_STEPS][BW-1] ? -ca[CORDIC_STEPS] : ca[CORDIC_STEPS];

    always_comb
    begin
        rnd  = ({1'b0, prod_reg} + ROUND) >> SH;
        rmag = rnd[AW-1:0];
        if (z_reg[ZL-1])
            angle_next = '0;
        else
            angle_next = pneg_reg ? -rmag : rmag;
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= a_abs[31:0];
        mneg_reg  <= ca[CORDIC_STEPS][BW-1];
        prod_reg  <= 64'(mag_reg) * 64'(PI30);
        pneg_reg  <= mneg_reg;
        angle_reg <= angle_next;
    end

    assign angle_out = angle_reg;

endmodule

>>> design/lidar_point_ring_and_time.sv
// ----------------------------------------------------------------------------
// lidar_point_ring_and_time: ring index and time offset of lidar points
// Elevation and azimuth of each point through pipelined cell chains.
// ----------------------------------------------------------------------------
// Usage:
//   A point word is taken at each rising edge where start is high and busy is
//   low. busy stays low, so one point may be offered in every cycle.
//   Each point yields one result word (ring_index, time_offset_us), shown for
//   one cycle with done high. Results leave in input order.
//   Throughput is one point per cycle: the cell chains (square-root cells, two
//   CORDIC chains, restoring divider cells) and all other stages advance on
//   every clock.
//   Latency is set by the elevation path: squares, one square-root cell per
//   coordinate bit, the CORDIC chain and the ring divider.
//   The APB port sets field of view, line count and revolution period; write
//   it only while no point is in flight. pready is always high.
//   Reset clears the in-flight markers and restores the register defaults.
//   The receiver cannot stall the block; results are not held.
// ----------------------------------------------------------------------------
module lidar_point_ring_and_time #(
    parameter int COORD_WIDTH     = lprt_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = lprt_pkg::ANGLE_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic                          ring_given,
    input  logic [15:0]                   ring_supplied,
    output logic                          done,
    output logic [15:0]                   ring_index,
    output logic [19:0]                   time_offset_us
);
    import lprt_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int F    = ANGLE_FRAC_BITS;
    localparam int AW   = F + 4;
    localparam int EW   = ((AW > 16) ? AW : 16) + 1;
    localparam int AZW  = F + 3;
    localparam int TRW  = AZW + 21;
    localparam int RRW  = 26;
    localparam int RQW  = 8;
    localparam int TQW  = 20;
    localparam int EL_LAT  = 54 + W;
    localparam int AZ_DLY  = W - 9;
    localparam int LAT     = EL_LAT + 2;
    localparam int ZD_LEN  = W + 3;
    localparam logic [63:0] TWO_PI_F = (64'(PI30) + (64'd1 << (28 - F))) >> (29 - F);
    localparam logic [AZW-1:0] TPF   = TWO_PI_F[AZW-1:0];

    // ---------------- configuration registers ----------------
    logic signed [15:0] fov_min_reg;
    logic signed [15:0] fov_max_reg;
    logic [7:0]         lines_reg;
    logic [19:0]        period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_min_reg <= FOV_MIN_RST;
            fov_max_reg <= FOV_MAX_RST;
            lines_reg   <= LINES_RST;
            period_reg  <= PERIOD_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                REG_FOV_MIN: fov_min_reg <= pwdata[15:0];
                REG_FOV_MAX: fov_max_reg <= pwdata[15:0];
                REG_LINES:   lines_reg   <= pwdata[7:0];
                REG_PERIOD:  period_reg  <= pwdata[19:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FOV_MIN: prdata = {{16{fov_min_reg[15]}}, fov_min_reg};
            REG_FOV_MAX: prdata = {{16{fov_max_reg[15]}}, fov_max_reg};
            REG_LINES:   prdata = {24'd0, lines_reg};
            REG_PERIOD:  prdata = {12'd0, period_reg};
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // ---------------- word tracking and side delay lines ----------------
    logic        vld_reg [LAT];
    logic        gd_reg  [EL_LAT+1];
    logic [15:0] rs_reg  [EL_LAT+1];
    logic signed [W-1:0] zd_reg [ZD_LEN];
    logic signed [W-1:0] px_reg, py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= pos_x;
        py_reg    <= pos_y;
        zd_reg[0] <= pos_z;
        gd_reg[0] <= ring_given;
        rs_reg[0] <= ring_supplied;
        for (int k = 1; k < ZD_LEN; k++)
            zd_reg[k] <= zd_reg[k-1];
        for (int k = 1; k <= EL_LAT; k++)
        begin
            gd_reg[k] <= gd_reg[k-1];
            rs_reg[k] <= rs_reg[k-1];
        end
    end

    // ---------------- horizontal range ----------------
    logic [W-1:0]   ax, ay;
    logic [2*W-1:0] sqx_reg, sqy_reg, sum_reg;

    assign ax = px_reg[W-1] ? (~px_reg + 1'b1) : px_reg;
    assign ay = py_reg[W-1] ? (~py_reg + 1'b1) : py_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg <= (2*W)'(ax) * (2*W)'(ax);
        sqy_reg <= (2*W)'(ay) * (2*W)'(ay);
        sum_reg <= sqx_reg + sqy_reg;
    end

    logic [2*W-1:0] s_rad  [W+1];
    logic [W-1:0]   s_root [W+1];
    logic [W+2:0]   s_rem  [W+1];

    assign s_rad[0]  = sum_reg;
    assign s_root[0] = '0;
    assign s_rem[0]  = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        lprt_sqrt_cell #(.W(W), .STEP(i)) u_cell (
            .clk      (clk),
            .rad_in   (s_rad[i]),
            .root_in  (s_root[i]),
            .rem_in   (s_rem[i]),
            .rad_out  (s_rad[i+1]),
            .root_out (s_root[i+1]),
            .rem_out  (s_rem[i+1])
        );
    end

    // ---------------- angles ----------------
    logic signed [AW-1:0] el_ang, az_ang;

    lprt_atan #(.IW(W+1), .AW(AW), .F(F)) u_elev (
        .clk       (clk),
        .y_in      ({zd_reg[ZD_LEN-1][W-1], zd_reg[ZD_LEN-1]}),
        .x_in      ({1'b0, s_root[W]}),
        .angle_out (el_ang)
    );

    lprt_atan #(.IW(W+1), .AW(AW), .F(F)) u_azim (
        .clk       (clk),
        .y_in      ({py_reg[W-1], py_reg}),
        .x_in      ({px_reg[W-1], px_reg}),
        .angle_out (az_ang)
    );

    // ---------------- ring from elevation ----------------
    logic signed [EW-1:0] el_e, fmin_e, fmax_e, el_c, el_d;
    logic [16:0]          den_full;
    logic [15:0]          den;
    logic [15:0]          diff_reg;
    logic [23:0]          num_reg;
    logic [RRW-1:0]       dvd_reg;
    logic [7:0]           lines_m1;

    always_comb
    begin
        el_e   = {{(EW-AW){el_ang[AW-1]}}, el_ang};
        fmin_e = {{(EW-16){fov_min_reg[15]}}, fov_min_reg};
        fmax_e = {{(EW-16){fov_max_reg[15]}}, fov_max_reg};
        el_c   = el_e;
        if (el_c > fmax_e)
            el_c = fmax_e;
        if (el_c < fmin_e)
            el_c = fmin_e;
        el_d     = el_c - fmin_e;
        den_full = {fov_max_reg[15], fov_max_reg} - {fov_min_reg[15], fov_min_reg};
        den      = den_full[15:0];
        lines_m1 = lines_reg - 8'd1;
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= el_d[15:0];
        num_reg  <= 24'(diff_reg) * 24'(lines_m1);
        dvd_reg  <= {1'b0, num_reg, 1'b0} + RRW'(den);
    end

    logic [RRW-1:0] r_rem [RQW+1];
    logic [RQW-1:0] r_quo [RQW+1];

    assign r_rem[0] = dvd_reg;
    assign r_quo[0] = '0;

    for (genvar i = 0; i < RQW; i++)
    begin : g_rdiv
        lprt_div_cell #(.RW(RRW), .QW(RQW), .DVW(17), .BIT(RQW-1-i)) u_cell (
            .clk     (clk),
            .rem_in  (r_rem[i]),
            .quo_in  (r_quo[i]),
            .divisor ({den, 1'b0}),
            .rem_out (r_rem[i+1]),
            .quo_out (r_quo[i+1])
        );
    end

    // ---------------- time from azimuth ----------------
    logic signed [AW:0]  az_s;
    logic [AZW-1:0]      azw_reg, azw_next;
    logic [AZW+19:0]     azp_reg;

    always_comb
    begin
        az_s = {az_ang[AW-1], az_ang};
        if (az_ang[AW-1])
            az_s = az_s + (AW+1)'(TPF);
        if (az_s[AW])
            azw_next = '0;
        else if (az_s > (AW+1)'(TPF - 1'b1))
            azw_next = TPF - 1'b1;
        else
            azw_next = az_s[AZW-1:0];
    end

    always_ff @(posedge clk)
    begin
        azw_reg <= azw_next;
        azp_reg <= (AZW+20)'(azw_reg) * (AZW+20)'(period_reg);
    end

    logic [TRW-1:0] t_rem [TQW+1];
    logic [TQW-1:0] t_quo [TQW+1];

    assign t_rem[0] = TRW'(azp_reg);
    assign t_quo[0] = '0;

    for (genvar i = 0; i < TQW; i++)
    begin : g_tdiv
        lprt_div_cell #(.RW(TRW), .QW(TQW), .DVW(AZW), .BIT(TQW-1-i)) u_cell (
            .clk     (clk),
            .rem_in  (t_rem[i]),
            .quo_in  (t_quo[i]),
            .divisor (TPF),
            .rem_out (t_rem[i+1]),
            .quo_out (t_quo[i+1])
        );
    end

    // The azimuth path is shorter; hold its result until the ring is ready.
    logic [TQW-1:0] td_reg [AZ_DLY];

    always_ff @(posedge clk)
    begin
        td_reg[0] <= t_quo[TQW];
        for (int k = 1; k < AZ_DLY; k++)
            td_reg[k] <= td_reg[k-1];
    end

    // ---------------- result word ----------------
    logic        ring_ok;
    logic [15:0] ring_idx_reg, ring_idx_next;
    logic [19:0] time_reg;

    assign ring_ok = (fov_max_reg > fov_min_reg) && (lines_reg != 8'd0);

    always_comb
    begin
        if (gd_reg[EL_LAT])
            ring_idx_next = rs_reg[EL_LAT];
        else if (!ring_ok)
            ring_idx_next = '0;
        else
            ring_idx_next = {8'd0, r_quo[RQW]};
    end

    always_ff @(posedge clk)
    begin
        ring_idx_reg <= ring_idx_next;
        time_reg     <= td_reg[AZ_DLY-1];
    end

    assign done           = vld_reg[LAT-1];
    assign ring_index     = ring_idx_reg;
    assign time_offset_us = time_reg;

    // ---------------- checks ----------------
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without a matching point word");

    a_time_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        done && (period_reg != 20'd0) |-> time_offset_us < period_reg)
        else $error("time offset beyond the revolution period");

    a_ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-2] && ring_ok |-> r_quo[RQW] < lines_reg)
        else $error("computed ring beyond the line count");

endmodule
